// ----- rtl/mtbc_pkg.sv -----
`timescale 1ns / 1ps
package mtbc_pkg;
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP_RD,
        ST_CMP,
        ST_PUSH,
        ST_EMIT_RD,
        ST_EMIT,
        ST_CORRECT
    } mtbc_state_t;

    typedef struct packed {
        logic is_err;
        logic from_stack;
        logic valid;
    } mtbc_emit_t;
endpackage

// ----- rtl/mtbc_stack_mem.sv -----
`timescale 1ns / 1ps
module mtbc_stack_mem #(
    parameter int AW     = 11,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [0:(1 << AW) - 1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/markup_tag_balance_checker.sv -----
`timescale 1ns / 1ps
// channel   dir  fields
// s_axis    in   tdata[7:0] text_byte, tlast end_of_doc
// m_axis    out  tdata[7:0] tag_char, tuser[0] verdict, tuser[1] char_valid, tlast final_res
//
// an ordinary byte is taken in the idle state; a closing tag compares one name byte per cycle
// through the shared compare unit
// an opening tag, if the stack has room, copies text and name into the stack memories, one byte per cycle
// error tag bytes and the verdict are output one per cycle, gated by m_tready
// asynchronous reset clears control only; stack memories are not cleared
module markup_tag_balance_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int TAG_LEN     = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // text_byte
    input  logic       s_tlast,   // end_of_doc
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // tag_char
    output logic [1:0] m_tuser,   // verdict, char_valid
    output logic       m_tlast    // final_res
);
    localparam int LW = $clog2(TAG_LEN + 1);
    localparam int IW = $clog2(TAG_LEN);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int DW = $clog2(STACK_DEPTH);
    localparam int AW = DW + IW;

    mtbc_pkg::mtbc_state_t state_reg, state_next;
    logic [7:0]    text_reg [0:TAG_LEN-1];
    logic [7:0]    name_reg [0:TAG_LEN-1];
    logic [LW-1:0] text_len_reg, name_len_reg;
    logic [SW-1:0] count_reg;
    logic          in_tag_reg, halted_reg, eod_reg;
    logic [LW-1:0] idx_reg;
    mtbc_pkg::mtbc_emit_t emit_reg;

    logic          acc;
    logic [7:0]    b;
    logic [DW-1:0] top, wr_slot;
    logic [7:0]    name_q, text_q;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic          closing;
    logic [LW-1:0] emit_len;
    logic          done_item;
    logic [LW-1:0] rd_idx;
    logic          push_last;
    logic          slen_we;
    logic [2*LW-1:0] slen_wdata, slen_q;

    assign acc = s_tvalid && s_tready;
    assign b = s_tdata;
    assign top = DW'(count_reg - SW'(1));
    assign wr_slot = count_reg[DW-1:0];
    assign closing = (text_len_reg >= LW'(2)) && (text_reg[1] == mtbc_pkg::CH_SLASH);
    assign we = (state_reg == mtbc_pkg::ST_PUSH);
    assign push_last = we && (idx_reg + LW'(1) >= text_len_reg);
    // registered read, so address the byte that is shown after this edge
    assign rd_idx = (state_reg == mtbc_pkg::ST_EMIT && m_tready) ? idx_reg + LW'(1)
                                                                  : idx_reg;
    assign waddr = {wr_slot, idx_reg[IW-1:0]};
    assign raddr = {top, rd_idx[IW-1:0]};

    mtbc_stack_mem #(.AW(AW), .DATA_W(8)) u_names (
        .clk(clk), .we(we && idx_reg < name_len_reg), .waddr(waddr),
        .wdata(name_reg[idx_reg[IW-1:0]]), .raddr(raddr), .rdata(name_q)
    );
    mtbc_stack_mem #(.AW(AW), .DATA_W(8)) u_texts (
        .clk(clk), .we(we), .waddr(waddr),
        .wdata(text_reg[idx_reg[IW-1:0]]), .raddr(raddr), .rdata(text_q)
    );

    // text length in the upper half, name length in the lower half
    assign slen_we = push_last;
    assign slen_wdata = {text_len_reg, name_len_reg};
    mtbc_stack_mem #(.AW(DW), .DATA_W(2 * LW)) u_lens (
        .clk(clk), .we(slen_we), .waddr(wr_slot),
        .wdata(slen_wdata), .raddr(top), .rdata(slen_q)
    );

    assign emit_len = emit_reg.from_stack ? slen_q[2*LW-1:LW] : text_len_reg;
    assign s_tready = (state_reg == mtbc_pkg::ST_IDLE);

    assign done_item = (state_reg == mtbc_pkg::ST_EMIT) && m_tready &&
                       (idx_reg + LW'(1) == emit_len);

    // a byte that ends a tag hands off to the sequencer unless halted; otherwise verdict or done
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtbc_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (!halted_reg && b == mtbc_pkg::CH_CLOSE && in_tag_reg)
                    begin
                        state_next = mtbc_pkg::ST_CMP_RD;
                    end
                    else if (s_tlast && !halted_reg)
                    begin
                        state_next = (count_reg != '0) ? mtbc_pkg::ST_EMIT_RD
                                                       : mtbc_pkg::ST_CORRECT;
                    end
                end
            end
            mtbc_pkg::ST_CMP_RD:
            begin
                if (!closing)
                begin
                    if (count_reg < SW'(STACK_DEPTH))
                    begin
                        state_next = mtbc_pkg::ST_PUSH;
                    end
                    else
                    begin
                        state_next = eod_reg ? mtbc_pkg::ST_EMIT_RD : mtbc_pkg::ST_IDLE;
                    end
                end
                else if (count_reg == '0 || slen_q[LW-1:0] != name_len_reg)
                begin
                    state_next = mtbc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = mtbc_pkg::ST_CMP;
                end
            end
            mtbc_pkg::ST_CMP:
            begin
                if (idx_reg > name_len_reg || idx_reg == '0)
                begin
                    if (eod_reg)
                    begin
                        state_next = (count_reg != SW'(1)) ? mtbc_pkg::ST_EMIT_RD
                                                           : mtbc_pkg::ST_CORRECT;
                    end
                    else
                    begin
                        state_next = mtbc_pkg::ST_IDLE;
                    end
                end
                else if (name_q != name_reg[idx_reg[IW-1:0] - IW'(1)])
                begin
                    state_next = mtbc_pkg::ST_EMIT;
                end
            end
            mtbc_pkg::ST_PUSH:
            begin
                if (push_last)
                begin
                    state_next = eod_reg ? mtbc_pkg::ST_EMIT_RD : mtbc_pkg::ST_IDLE;
                end
            end
            mtbc_pkg::ST_EMIT_RD: state_next = mtbc_pkg::ST_EMIT;
            mtbc_pkg::ST_EMIT:
            begin
                if (done_item)
                begin
                    state_next = mtbc_pkg::ST_IDLE;
                end
            end
            mtbc_pkg::ST_CORRECT:
            begin
                if (m_tready)
                begin
                    state_next = mtbc_pkg::ST_IDLE;
                end
            end
            default: state_next = mtbc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        m_tvalid = 1'b0;
        m_tdata = '0;
        m_tuser = '0;
        m_tlast = 1'b0;
        case (state_reg)
            mtbc_pkg::ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tdata = emit_reg.from_stack ? text_q : text_reg[idx_reg[IW-1:0]];
                m_tuser = 2'b11;
                m_tlast = (idx_reg + LW'(1) == emit_len);
            end
            mtbc_pkg::ST_CORRECT:
            begin
                m_tvalid = 1'b1;
                m_tlast = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtbc_pkg::ST_IDLE;
            count_reg <= '0;
            in_tag_reg <= 1'b0;
            halted_reg <= 1'b0;
            text_len_reg <= '0;
            name_len_reg <= '0;
            eod_reg <= 1'b0;
            idx_reg <= '0;
            emit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mtbc_pkg::ST_IDLE:
                begin
                    if (acc)
                    begin
                        eod_reg <= s_tlast;
                        idx_reg <= '0;
                        emit_reg <= '{is_err: 1'b1, from_stack: 1'b1, valid: 1'b1};
                        if (!halted_reg)
                        begin
                            if (b == mtbc_pkg::CH_OPEN)
                            begin
                                in_tag_reg <= 1'b1;
                                text_reg[0] <= b;
                                text_len_reg <= LW'(1);
                                name_len_reg <= '0;
                            end
                            else if (in_tag_reg && text_len_reg < LW'(TAG_LEN))
                            begin
                                text_reg[text_len_reg[IW-1:0]] <= b;
                                text_len_reg <= text_len_reg + LW'(1);
                                if (b != mtbc_pkg::CH_CLOSE && b != mtbc_pkg::CH_SLASH)
                                begin
                                    name_reg[name_len_reg[IW-1:0]] <= b;
                                    name_len_reg <= name_len_reg + LW'(1);
                                end
                            end
                            if (b == mtbc_pkg::CH_CLOSE && in_tag_reg)
                            begin
                                in_tag_reg <= 1'b0;
                            end
                        end
                        if (s_tlast && !(!halted_reg && b == mtbc_pkg::CH_CLOSE
                                         && in_tag_reg))
                        begin
                            in_tag_reg <= 1'b0;
                            halted_reg <= 1'b0;
                            text_len_reg <= '0;
                            name_len_reg <= '0;
                            if (halted_reg || count_reg == '0)
                            begin
                                count_reg <= '0;
                            end
                        end
                    end
                end
                mtbc_pkg::ST_CMP_RD:
                begin
                    if (closing)
                    begin
                        if (count_reg == '0 || slen_q[LW-1:0] != name_len_reg)
                        begin
                            emit_reg <= '{is_err: 1'b1, from_stack: 1'b0, valid: 1'b1};
                            halted_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= LW'(1);
                        end
                    end
                end
                mtbc_pkg::ST_CMP:
                begin
                    // shared compare unit: one name byte per cycle
                    if (idx_reg > name_len_reg || idx_reg == '0)
                    begin
                        count_reg <= count_reg - SW'(1);
                        idx_reg <= '0;
                    end
                    else if (name_q != name_reg[idx_reg[IW-1:0] - IW'(1)])
                    begin
                        emit_reg <= '{is_err: 1'b1, from_stack: 1'b0, valid: 1'b1};
                        halted_reg <= 1'b1;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + LW'(1);
                    end
                end
                mtbc_pkg::ST_PUSH:
                begin
                    if (push_last)
                    begin
                        count_reg <= count_reg + SW'(1);
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + LW'(1);
                    end
                end
                mtbc_pkg::ST_EMIT_RD:
                begin
                    emit_reg <= '{is_err: 1'b1, from_stack: 1'b1, valid: 1'b1};
                end
                mtbc_pkg::ST_EMIT:
                begin
                    if (m_tready)
                    begin
                        if (done_item)
                        begin
                            idx_reg <= '0;
                            if (eod_reg)
                            begin
                                count_reg <= '0;
                                halted_reg <= 1'b0;
                                in_tag_reg <= 1'b0;
                                text_len_reg <= '0;
                                name_len_reg <= '0;
                            end
                        end
                        else
                        begin
                            idx_reg <= idx_reg + LW'(1);
                        end
                    end
                end
                mtbc_pkg::ST_CORRECT:
                begin
                    if (m_tready)
                    begin
                        count_reg <= '0;
                        halted_reg <= 1'b0;
                        in_tag_reg <= 1'b0;
                        text_len_reg <= '0;
                        name_len_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    property p_halt_blocks;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == mtbc_pkg::ST_EMIT && !emit_reg.from_stack) |-> halted_reg;
    endproperty
    a_halt_blocks: assert property (p_halt_blocks) else $error("error without halt");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= SW'(STACK_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("stack overflow");

    property p_len_bound;
        @(posedge clk) disable iff (!rst_n)
        (text_len_reg <= LW'(TAG_LEN)) && (name_len_reg <= text_len_reg);
    endproperty
    a_len_bound: assert property (p_len_bound) else $error("tag length");

    property p_idx;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == mtbc_pkg::ST_EMIT) |-> (idx_reg < emit_len);
    endproperty
    a_idx: assert property (p_idx) else $error("emit index");
endmodule
